FILE: rtl/core/slpe_pkg.sv
// Shared types, constants and pattern tables for the status LED pattern engine.
// Used by status_led_pattern_engine; depends on nothing else.
`default_nettype none

package slpe_pkg;

    localparam int TIME_WIDTH = 32;
    localparam int ON_W       = 11;
    localparam int PERIOD_W   = 12;
    localparam int CNT_W      = $clog2(TIME_WIDTH + 1);

    localparam logic [1:0] OP_TICK    = 2'd0;
    localparam logic [1:0] OP_BASE    = 2'd1;
    localparam logic [1:0] OP_OVERLAY = 2'd2;
    localparam logic [1:0] OP_START   = 2'd3;

    // Base status codes.
    localparam logic [2:0] ST_NONE        = 3'd0;
    localparam logic [2:0] ST_NORMAL      = 3'd1;
    localparam logic [2:0] ST_CONFIGURING = 3'd2;
    localparam logic [2:0] ST_FACTORY     = 3'd3;
    localparam logic [2:0] ST_FAILED      = 3'd4;

    // Overlay status codes.
    localparam logic [2:0] OV_NONE   = 3'd0;
    localparam logic [2:0] OV_SLAVE  = 3'd1;
    localparam logic [2:0] OV_MASTER = 3'd2;

    // Level of one colour channel in a pattern.
    localparam logic [1:0] CH_OFF  = 2'd0;
    localparam logic [1:0] CH_FULL = 2'd1;
    localparam logic [1:0] CH_PART = 2'd2;

    // Register map.
    localparam logic [2:0] ADDR_BRIGHTNESS  = 3'd0;
    localparam logic [7:0] BRIGHTNESS_RESET = 8'd255;

    localparam logic [2:0] OVERLAY_MAX = OV_MASTER;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] now_ms;
        logic [2:0]  status_code;
    } t_in;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_out;

    typedef struct packed {
        logic [1:0]      red;
        logic [1:0]      green;
        logic [1:0]      blue;
        logic [ON_W-1:0] on_ms;
        logic [ON_W-1:0] off_ms;
    } t_pat;

    // Yellow is full red with 160 green; green and red are full single channels.
    function automatic t_pat base_pat(input logic [2:0] code);
        t_pat p;
        p = '{CH_OFF, CH_OFF, CH_OFF, ON_W'(0), ON_W'(0)};
        unique case (code)
            ST_NORMAL:      p = '{CH_OFF,  CH_FULL, CH_OFF, ON_W'(50),   ON_W'(2000)};
            ST_CONFIGURING: p = '{CH_FULL, CH_PART, CH_OFF, ON_W'(50),   ON_W'(2000)};
            ST_FACTORY:     p = '{CH_FULL, CH_PART, CH_OFF, ON_W'(50),   ON_W'(50)};
            ST_FAILED:      p = '{CH_FULL, CH_OFF,  CH_OFF, ON_W'(1000), ON_W'(500)};
            default:        p = '{CH_OFF,  CH_OFF,  CH_OFF, ON_W'(0),    ON_W'(0)};
        endcase
        return p;
    endfunction

    function automatic t_pat overlay_pat(input logic [2:0] code);
        t_pat p;
        p = '{CH_OFF, CH_OFF, CH_OFF, ON_W'(0), ON_W'(0)};
        unique case (code)
            OV_SLAVE:  p = '{CH_FULL, CH_PART, CH_OFF, ON_W'(200), ON_W'(200)};
            OV_MASTER: p = '{CH_FULL, CH_PART, CH_OFF, ON_W'(1),   ON_W'(0)};
            default:   p = '{CH_OFF,  CH_OFF,  CH_OFF, ON_W'(0),   ON_W'(0)};
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/status_led_pattern_engine.sv
// Status LED pattern engine: request decode, bit-serial phase modulo and colour output.
// Depends on slpe_pkg for types, constants and the pattern tables.
`default_nettype none

// The engine takes one request at a time on the input channel. Set-status
// requests are handled in the idle state alone, as is a start request once
// the engine has started; only the first start request goes on to emit. A
// tick takes the request and forms the elapsed time (a 32-bit time base as
// slpe_pkg stands), runs the restoring modulo unit that reduces the elapsed
// time by the pattern period one time bit at a time, then decides whether the
// LED is lit and forms the scaled brightness product, and then emits. The
// modulo unit handles a single bit per cycle, which sets the tick latency. A
// result sits in an output register, so a new request is taken while the
// previous colour still waits on the output; the engine only pauses in its
// emit state when a fresh colour finds that register still full. A colour
// equal to the last one delivered is dropped, so a tick yields at most one
// result. The brightness register lives at address 0 of the APB-style port and must only be written while idle.

module status_led_pattern_engine (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output      logic              o_in_ready,
    input  wire slpe_pkg::t_in     i_in,
    output      logic              o_out_valid,
    input  wire logic              i_out_ready,
    output      slpe_pkg::t_out    o_out,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [2:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output      logic [31:0]       prdata,
    output      logic              pready
);

    localparam int TW = slpe_pkg::TIME_WIDTH;
    localparam int PW = slpe_pkg::PERIOD_W;
    localparam int CW = slpe_pkg::CNT_W;

    // Sequencer states.
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_DIV   = 2'd1;
    localparam logic [1:0] S_SCALE = 2'd2;
    localparam logic [1:0] S_EMIT  = 2'd3;

    logic [1:0]          r_state, n_state;
    logic [7:0]          r_brightness;
    logic [2:0]          r_base, n_base;
    logic [1:0]          r_overlay, n_overlay;
    logic                r_restart, n_restart;
    logic [TW-1:0]       r_start_ms, n_start_ms;
    logic                r_ready, n_ready;
    logic                r_has_shown, n_has_shown;
    logic [23:0]         r_shown, n_shown;

    // Working registers of the tick datapath.
    slpe_pkg::t_pat      r_pat, n_pat;
    logic [PW-1:0]       r_period, n_period;
    logic [TW-1:0]       r_dividend, n_dividend;
    logic [PW-1:0]       r_rem, n_rem;
    logic [CW-1:0]       r_cnt, n_cnt;
    logic                r_lit, n_lit;
    logic [15:0]         r_prod, n_prod;

    logic                r_out_valid, n_out_valid;
    slpe_pkg::t_out      r_out, n_out;

    logic                w_accept;
    logic                w_cfg_wr;
    logic [TW-1:0]       w_now;
    logic [TW-1:0]       w_start_eff;
    slpe_pkg::t_pat      w_sel_pat;
    logic [PW:0]         w_trial;
    logic [PW:0]         w_period_ext;
    logic [16:0]         w_div_sum;
    logic [7:0]          w_part_lvl;
    logic [7:0]          w_full_lvl;
    logic [23:0]         w_colour;
    logic                w_suppress;

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Configuration port: zero wait states, single byte-wide register.
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && (paddr == slpe_pkg::ADDR_BRIGHTNESS);
    assign prdata   = (paddr == slpe_pkg::ADDR_BRIGHTNESS) ? {24'd0, r_brightness} : 32'd0;

    // The time base is taken modulo 2^TIME_WIDTH throughout.
    assign w_now       = TW'(i_in.now_ms);
    assign w_start_eff = r_restart ? w_now : r_start_ms;

    // An active overlay wins over the base status.
    assign w_sel_pat = ({1'b0, r_overlay} != slpe_pkg::OV_NONE)
                     ? slpe_pkg::overlay_pat({1'b0, r_overlay})
                     : slpe_pkg::base_pat(r_base);

    // One restoring step: bring in the next dividend bit, subtract when it fits.
    assign w_trial      = {r_rem, r_dividend[TW-1]};
    assign w_period_ext = {1'b0, r_period};

    // Divide by 255 with rounding already folded into the product; the
    // shift-and-add form is exact for every product that can occur here.
    assign w_div_sum  = {1'b0, r_prod} + {9'd0, r_prod[15:8]} + 17'd1;
    assign w_part_lvl = (w_div_sum[15:8] == 8'd0) ? 8'd1 : w_div_sum[15:8];
    // A full channel scales to the brightness itself, but never below 1.
    assign w_full_lvl = (r_brightness == 8'd0) ? 8'd1 : r_brightness;

    function automatic logic [7:0] chan_level(input logic [1:0] code,
                                              input logic [7:0] full_lvl,
                                              input logic [7:0] part_lvl);
        logic [7:0] lvl;
        lvl = 8'd0;
        unique case (code)
            slpe_pkg::CH_FULL: lvl = full_lvl;
            slpe_pkg::CH_PART: lvl = part_lvl;
            default:           lvl = 8'd0;
        endcase
        return lvl;
    endfunction

    assign w_colour = r_lit ? {chan_level(r_pat.red,   w_full_lvl, w_part_lvl),
                               chan_level(r_pat.green, w_full_lvl, w_part_lvl),
                               chan_level(r_pat.blue,  w_full_lvl, w_part_lvl)}
                            : 24'd0;

    // A colour equal to the one last delivered is not sent again.
    assign w_suppress = r_has_shown && (w_colour == r_shown);

    always_comb begin
        n_state     = r_state;
        n_base      = r_base;
        n_overlay   = r_overlay;
        n_restart   = r_restart;
        n_start_ms  = r_start_ms;
        n_ready     = r_ready;
        n_has_shown = r_has_shown;
        n_shown     = r_shown;
        n_pat       = r_pat;
        n_period    = r_period;
        n_dividend  = r_dividend;
        n_rem       = r_rem;
        n_cnt       = r_cnt;
        n_lit       = r_lit;
        n_prod      = r_prod;
        n_out_valid = r_out_valid;
        n_out       = r_out;

        // The output register empties as soon as its result is taken.
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    unique case (i_in.op)
                        slpe_pkg::OP_START: begin
                            // Only the first start request shows dark.
                            if (!r_ready) begin
                                n_ready     = 1'b1;
                                n_has_shown = 1'b0;
                                n_lit       = 1'b0;
                                n_state     = S_EMIT;
                            end
                        end
                        slpe_pkg::OP_BASE: begin
                            if (i_in.status_code != r_base) begin
                                n_base = i_in.status_code;
                                if ({1'b0, r_overlay} == slpe_pkg::OV_NONE) begin
                                    n_restart = 1'b1;
                                end
                            end
                        end
                        slpe_pkg::OP_OVERLAY: begin
                            // Unknown overlay codes are ignored.
                            if ((i_in.status_code <= slpe_pkg::OVERLAY_MAX) &&
                                (i_in.status_code != {1'b0, r_overlay})) begin
                                n_overlay = i_in.status_code[1:0];
                                n_restart = 1'b1;
                            end
                        end
                        default: begin
                            // Tick: nothing is shown before the engine is started.
                            if (r_ready) begin
                                n_restart  = 1'b0;
                                n_start_ms = w_start_eff;
                                n_dividend = w_now - w_start_eff;
                                n_pat      = w_sel_pat;
                                n_period   = {1'b0, w_sel_pat.on_ms} + {1'b0, w_sel_pat.off_ms};
                                n_rem      = '0;
                                n_cnt      = CW'(TW);
                                n_state    = S_DIV;
                            end
                        end
                    endcase
                end
            end
            S_DIV: begin
                if (w_trial >= w_period_ext) begin
                    n_rem = PW'(w_trial - w_period_ext);
                end else begin
                    n_rem = w_trial[PW-1:0];
                end
                n_dividend = {r_dividend[TW-2:0], 1'b0};
                n_cnt      = r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    n_state = S_SCALE;
                end
            end
            S_SCALE: begin
                // Zero on time is dark, zero off time is solid, else compare the phase.
                if (r_pat.on_ms == '0) begin
                    n_lit = 1'b0;
                end else if (r_pat.off_ms == '0) begin
                    n_lit = 1'b1;
                end else begin
                    n_lit = (r_rem < {1'b0, r_pat.on_ms});
                end
                // 160 * brightness + 127, the rounded numerator for the partial channel.
                n_prod  = {1'b0, r_brightness, 7'd0} + {3'd0, r_brightness, 5'd0} + 16'd127;
                n_state = S_EMIT;
            end
            default: begin
                // Emit: wait only if a fresh colour meets a full output register.
                if (w_suppress) begin
                    n_state = S_IDLE;
                end else if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out       = '{w_colour[23:16], w_colour[15:8], w_colour[7:0]};
                    n_shown     = w_colour;
                    n_has_shown = 1'b1;
                    n_state     = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_brightness <= slpe_pkg::BRIGHTNESS_RESET;
            r_base       <= slpe_pkg::ST_NONE;
            r_overlay    <= 2'(slpe_pkg::OV_NONE);
            r_restart    <= 1'b1;
            r_start_ms   <= '0;
            r_ready      <= 1'b0;
            r_has_shown  <= 1'b0;
            r_shown      <= 24'd0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_base      <= n_base;
            r_overlay   <= n_overlay;
            r_restart   <= n_restart;
            r_start_ms  <= n_start_ms;
            r_ready     <= n_ready;
            r_has_shown <= n_has_shown;
            r_shown     <= n_shown;
            r_out_valid <= n_out_valid;
            if (w_cfg_wr) begin
                r_brightness <= pwdata[7:0];
            end
        end
    end

    // Datapath registers carry no reset.
    always_ff @(posedge i_clk) begin
        r_pat      <= n_pat;
        r_period   <= n_period;
        r_dividend <= n_dividend;
        r_rem      <= n_rem;
        r_cnt      <= n_cnt;
        r_lit      <= n_lit;
        r_prod     <= n_prod;
        r_out      <= n_out;
    end

endmodule

`default_nettype wire
